// ===== rtl/core/nec_ir_frame_receiver_macros.svh =====
// Assertion macros shared by the NEC infrared receiver RTL.
`ifndef NEC_IR_FRAME_RECEIVER_MACROS_SVH
`define NEC_IR_FRAME_RECEIVER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define NIR_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("NEC receiver assertion failed");

// Antecedent implies consequent in the following cycle.
`define NIR_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("NEC receiver assertion failed");

`endif

// ===== rtl/core/nir_pkg.sv =====
// Types, constants and helper functions for the NEC infrared receiver.
package nir_pkg;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_RISE = 2'd1,
    MODE_FALL = 2'd2,
    MODE_SCAN = 2'd3
  } mode_t;

  localparam logic [3:0]  TIMEOUT_RESET = 4'd14;
  localparam logic [13:0] ZERO_LO   = 14'd300;
  localparam logic [13:0] ZERO_HI   = 14'd800;
  localparam logic [13:0] ONE_LO    = 14'd1400;
  localparam logic [13:0] ONE_HI    = 14'd1800;
  localparam logic [13:0] REPEAT_LO = 14'd2200;
  localparam logic [13:0] REPEAT_HI = 14'd2600;
  localparam logic [13:0] LEAD_LO   = 14'd4200;
  localparam logic [13:0] LEAD_HI   = 14'd4700;

  typedef struct packed {
    logic        lead;
    logic        ready;
    logic        rise;
    logic [3:0]  tick_count;
    logic [31:0] bits;
    logic [7:0]  repeats;
    logic [7:0]  held_key;
    logic [7:0]  held_address;
  } rx_state_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/nir_decode.sv =====
// Next-state logic of the NEC receiver for one event.
module nir_decode (
  input  nir_pkg::rx_state_t st,
  input  nir_pkg::mode_t     mode,
  input  logic [13:0]        high_us,
  input  logic [3:0]         timeout_ticks,
  output nir_pkg::rx_state_t st_next
);

  logic [7:0] addr;
  logic [7:0] naddr;
  logic [7:0] cmd;
  logic [7:0] ncmd;
  logic [7:0] key_new;

  assign addr  = st.bits[31:24];
  assign naddr = st.bits[23:16];
  assign cmd   = st.bits[15:8];
  assign ncmd  = st.bits[7:0];

  always_comb begin
    st_next = st;
    key_new = st.held_key;
    case (mode)
      nir_pkg::MODE_TICK: begin
        if (st.lead) begin
          st_next.rise = 1'b0;
          if (st.tick_count == 4'd0) begin
            st_next.ready = 1'b1;
          end
          if (st.tick_count < timeout_ticks) begin
            st_next.tick_count = st.tick_count + 4'd1;
          end else begin
            st_next.lead       = 1'b0;
            st_next.tick_count = 4'd0;
          end
        end
      end
      nir_pkg::MODE_RISE: begin
        st_next.rise = 1'b1;
      end
      nir_pkg::MODE_FALL: begin
        st_next.rise = 1'b0;
        if (st.rise) begin
          if (st.lead) begin
            if (high_us inside {[nir_pkg::ZERO_LO + 14'd1 : nir_pkg::ZERO_HI - 14'd1]}) begin
              st_next.bits = {st.bits[30:0], 1'b0};
            end else if (high_us inside
                         {[nir_pkg::ONE_LO + 14'd1 : nir_pkg::ONE_HI - 14'd1]}) begin
              st_next.bits = {st.bits[30:0], 1'b1};
            end else if (high_us inside
                         {[nir_pkg::REPEAT_LO + 14'd1 : nir_pkg::REPEAT_HI - 14'd1]}) begin
              st_next.repeats    = st.repeats + 8'd1;
              st_next.tick_count = 4'd0;
            end
          end else if (high_us inside
                       {[nir_pkg::LEAD_LO + 14'd1 : nir_pkg::LEAD_HI - 14'd1]}) begin
            st_next.lead    = 1'b1;
            st_next.repeats = 8'd0;
          end
        end
      end
      nir_pkg::MODE_SCAN: begin
        if (st.ready) begin
          if (addr == ~naddr) begin
            key_new              = (cmd == ~ncmd) ? nir_pkg::reverse8(cmd) : 8'd0;
            st_next.held_key     = key_new;
            st_next.held_address = nir_pkg::reverse8(addr);
          end
          if (key_new == 8'd0 || !st.lead) begin
            st_next.ready   = 1'b0;
            st_next.repeats = 8'd0;
          end
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

// ===== rtl/core/nec_ir_frame_receiver.sv =====
// Top level of the NEC infrared frame receiver.
// Input stream: each transfer is one event. s_axis_tuser carries the event kind
// (tick, rising edge, falling edge, scan) and s_axis_tdata the measured high
// time in microseconds, which only a falling edge uses.
// Output stream: exactly one transfer per event, holding the key code, device
// address, repeat count and the ready and lead flags as they stand after it.
// The configuration channel writes the timeout in overflow ticks; it is always
// ready and should only be written while no event is in flight.
// Each event passes through the input register, then through the decode logic
// into the state and output registers.
// Throughput is one event per cycle, limited only by the output handshake.
// When the output is stalled the input register holds one further event, and
// then s_axis_tready falls until the output transfer completes.
// Reset clears all decoder state and sets the timeout to 14 ticks.
`include "nec_ir_frame_receiver_macros.svh"

module nec_ir_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [13:0] high_us, [15:14] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] key_code, [15:8] device_address, [23:16] repeat_count,
  // [24] key_ready, [25] lead_seen, [31:26] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  logic               in_valid;
  nir_pkg::mode_t     in_mode;
  logic [13:0]        in_us;
  logic [3:0]         timeout_ticks;
  nir_pkg::rx_state_t st;
  nir_pkg::rx_state_t st_next;
  logic               advance;
  logic               out_valid;
  logic [31:0]        out_data;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= nir_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode <= nir_pkg::mode_t'(s_axis_tuser);
      in_us   <= s_axis_tdata[13:0];
    end
  end

  nir_decode u_decode (
    .st            (st),
    .mode          (in_mode),
    .high_us       (in_us),
    .timeout_ticks (timeout_ticks),
    .st_next       (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= {6'd0, st_next.lead, st_next.ready, st_next.repeats,
                   st_next.held_address, st_next.held_key};
    end
  end

  `NIR_ASSERT_SAME(a_idle_tick_count, clk, rst, !st.lead, st.tick_count == 4'd0)
  `NIR_ASSERT_SAME(a_lead_clears_repeats, clk, rst, $rose(st.lead), st.repeats == 8'd0)
  `NIR_ASSERT_NEXT(a_event_gives_result, clk, rst, in_valid && advance, out_valid)
  `NIR_ASSERT_NEXT(a_rise_cleared, clk, rst,
                   in_valid && advance && in_mode == nir_pkg::MODE_FALL, !st.rise)

endmodule
